// ===== design/bqrhd_pkg.sv =====
// ----------------------------------------------------------------------------
// bqrhd_pkg: shared types and constants of the bounded queue
// Command and status codes, back-end states, config write bundle and the
// 16-bit Galois LFSR step used by the random drop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bqrhd_pkg;

   localparam int DEPTH_DEFAULT     = 16;
   localparam int TIME_BITS_DEFAULT = 48;

   localparam logic [4:0]  LIMIT_RESET = 5'd16;
   localparam logic [15:0] SEED_RESET  = 16'd1;
   localparam logic [15:0] LFSR_TAPS   = 16'hB400;

   // register indexes, decoded from address bit 2
   localparam logic REG_LIMIT = 1'b0;
   localparam logic REG_SEED  = 1'b1;

   // status codes
   localparam logic [2:0] ST_ACCEPTED = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_DEQUEUED = 3'd2;
   localparam logic [2:0] ST_EMPTY    = 3'd3;
   localparam logic [2:0] ST_REMOVED  = 3'd4;

   typedef enum logic [1:0] {
      CMD_ENQ  = 2'd0,
      CMD_DEQ  = 2'd1,
      CMD_DROP = 2'd2
   } cmd_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_ENQ,
      BK_EMPTY,
      BK_DEQ_RD,
      BK_DEQ_EMIT,
      BK_DRAW,
      BK_MOD_WAIT,
      BK_WALK_RD,
      BK_WALK_CHK
   } back_state_type;

   // seed load request from the register block
   typedef struct packed {
      logic        seed_load;
      logic [15:0] seed;
   } seed_wr_type;

   // one Galois step: shift right, xor taps when a one falls out
   function automatic logic [15:0] lfsr_step(input logic [15:0] v);
      logic [15:0] s;
      s = v >> 1;
      if (v[0]) begin
         s = s ^ LFSR_TAPS;
      end
      return s;
   endfunction

endpackage
`default_nettype wire

// ===== design/bounded_queue_random_half_drop.sv =====
// ----------------------------------------------------------------------------
// bounded_queue_random_half_drop: bounded queue with random half drop
// Front intake queue, back queue engine with entry memory, and the
// configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
// Drop half: each random draw uses the serial remainder unit, one bit per
// cycle, plus a redraw for each repeat; then every entry is walked through
// the memory read and write ports. Commands are carried out one at a time.
// Reset (synchronous): queue empty, limit 16, seed and generator 1.
`timescale 1ns / 1ps
`default_nettype none
module bounded_queue_random_half_drop #(
   parameter int DEPTH     = bqrhd_pkg::DEPTH_DEFAULT,
   parameter int TIME_BITS = bqrhd_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [2:0]           paddr,
   input  wire logic [31:0]          pwdata,
   output logic [31:0]               prdata,
   output logic                      pready,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           req_command,
   input  wire logic [15:0]          req_conn_id,
   input  wire logic [TIME_BITS-1:0] req_arrival_time,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [2:0]                rsp_status,
   output logic [15:0]               rsp_out_conn,
   output logic [TIME_BITS-1:0]      rsp_out_time,
   output logic [3:0]                rsp_removed_count,
   output logic                      rsp_last
);
   import bqrhd_pkg::*;

   logic [4:0]           limit_ff, limit_in;
   logic [15:0]          seed_ff, seed_in;
   logic                 wr;
   seed_wr_type          seed_wr;
   logic                 q_valid, q_pop;
   logic [1:0]           q_cmd;
   logic [15:0]          q_conn;
   logic [TIME_BITS-1:0] q_time;

   // register write transfer
   assign pready = 1'b1;
   assign wr = psel && penable && pwrite && pready;

   always_comb begin
      limit_in = limit_ff;
      seed_in  = seed_ff;
      if (wr && paddr[2] == REG_LIMIT) begin
         limit_in = pwdata[4:0];
      end
      if (wr && paddr[2] == REG_SEED) begin
         seed_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         seed_ff  <= SEED_RESET;
      end else begin
         limit_ff <= limit_in;
         seed_ff  <= seed_in;
      end
   end

   assign seed_wr.seed_load = wr && (paddr[2] == REG_SEED);
   assign seed_wr.seed      = pwdata[15:0];

   // register read
   assign prdata = (paddr[2] == REG_SEED) ? {16'd0, seed_ff} : {27'd0, limit_ff};

   bqrhd_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_conn_id      (req_conn_id),
      .req_arrival_time (req_arrival_time),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_cmd            (q_cmd),
      .q_conn           (q_conn),
      .q_time           (q_time)
   );

   bqrhd_back #(
      .DEPTH     (DEPTH),
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_limit       (limit_ff),
      .seed_wr           (seed_wr),
      .q_valid           (q_valid),
      .q_pop             (q_pop),
      .q_cmd             (q_cmd),
      .q_conn            (q_conn),
      .q_time            (q_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_out_conn      (rsp_out_conn),
      .rsp_out_time      (rsp_out_time),
      .rsp_removed_count (rsp_removed_count),
      .rsp_last          (rsp_last)
   );

endmodule
`default_nettype wire

// ===== design/bqrhd_front.sv =====
// ----------------------------------------------------------------------------
// bqrhd_front: request intake
// Accepts request transfers, discards the unused command code and keeps up
// to two commands in a small queue in front of the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bqrhd_front #(
   parameter int TIME_BITS = bqrhd_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           req_command,
   input  wire logic [15:0]          req_conn_id,
   input  wire logic [TIME_BITS-1:0] req_arrival_time,
   output logic                      q_valid,
   input  wire logic                 q_pop,
   output logic [1:0]                q_cmd,
   output logic [15:0]               q_conn,
   output logic [TIME_BITS-1:0]      q_time
);
   import bqrhd_pkg::*;

   logic [1:0]           count_ff, count_in;
   logic [1:0]           cmd_ff  [2];
   logic [15:0]          conn_ff [2];
   logic [TIME_BITS-1:0] time_ff [2];
   logic                 push;
   logic                 known;

   // classify: only the three defined commands enter the queue
   assign known = (req_command == CMD_ENQ) || (req_command == CMD_DEQ)
                  || (req_command == CMD_DROP);
   assign req_ready = (count_ff != 2'd2);
   assign push = req_valid && req_ready && known;

   assign q_valid = (count_ff != 2'd0);
   assign q_cmd   = cmd_ff[0];
   assign q_conn  = conn_ff[0];
   assign q_time  = time_ff[0];

   // occupancy of the queue
   always_comb begin
      count_in = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   // shifting entries, head in slot zero
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff[0]  <= cmd_ff[1];
         conn_ff[0] <= conn_ff[1];
         time_ff[0] <= time_ff[1];
      end
      if (push) begin
         if ((q_pop && count_ff == 2'd1) || count_ff == 2'd0) begin
            cmd_ff[0]  <= req_command;
            conn_ff[0] <= req_conn_id;
            time_ff[0] <= req_arrival_time;
         end else begin
            cmd_ff[1]  <= req_command;
            conn_ff[1] <= req_conn_id;
            time_ff[1] <= req_arrival_time;
         end
      end
   end

endmodule
`default_nettype wire

// ===== design/bqrhd_mod.sv =====
// ----------------------------------------------------------------------------
// bqrhd_mod: serial remainder unit
// Restoring remainder of a 16-bit value by the occupancy, one dividend bit
// per cycle; done pulses with the remainder after sixteen steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bqrhd_mod #(
   parameter int OW = 5
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [15:0]   dividend,
   input  wire logic [OW-1:0] divisor,
   output logic               done,
   output logic [OW-1:0]      remainder
);
   import bqrhd_pkg::*;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [3:0]    step_ff, step_in;
   logic [15:0]   dvd_ff, dvd_in;
   logic [OW-1:0] rem_ff, rem_in;
   logic [OW-1:0] div_ff, div_in;
   logic [OW:0]   trial;

   assign trial = {rem_ff, dvd_ff[15]};

   // one shift and conditional subtract per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 4'd0;
         dvd_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         if (trial >= {1'b0, div_ff}) begin
            rem_in = OW'(trial - {1'b0, div_ff});
         end else begin
            rem_in = OW'(trial);
         end
         step_in = step_ff + 4'd1;
         if (step_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// ===== design/bqrhd_back.sv =====
// ----------------------------------------------------------------------------
// bqrhd_back: queue engine
// Holds the entry memory and the circular queue state, carries out enqueue,
// dequeue and random half drop, and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bqrhd_back #(
   parameter int DEPTH     = bqrhd_pkg::DEPTH_DEFAULT,
   parameter int TIME_BITS = bqrhd_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [4:0]               queue_limit,
   input  wire bqrhd_pkg::seed_wr_type   seed_wr,
   input  wire logic                     q_valid,
   output logic                          q_pop,
   input  wire logic [1:0]               q_cmd,
   input  wire logic [15:0]              q_conn,
   input  wire logic [TIME_BITS-1:0]     q_time,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [2:0]                    rsp_status,
   output logic [15:0]                   rsp_out_conn,
   output logic [TIME_BITS-1:0]          rsp_out_time,
   output logic [3:0]                    rsp_removed_count,
   output logic                          rsp_last
);
   import bqrhd_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OW = $clog2(DEPTH + 1);
   localparam int LW = (OW > 5) ? OW : 5;

   back_state_type state_ff, state_in;

   logic [OW-1:0]        occ_ff, occ_in;
   logic [IW-1:0]        head_ff, head_in;
   logic [15:0]          lfsr_ff, lfsr_in;
   logic [DEPTH-1:0]     mask_ff, mask_in;
   logic [OW-1:0]        n_ff, n_in;
   logic [OW-1:0]        cnt_ff, cnt_in;
   logic [OW-1:0]        p_ff, p_in;
   logic [OW-1:0]        w_ff, w_in;
   logic [OW-1:0]        k_ff, k_in;
   logic [15:0]          conn_ff, conn_in;
   logic [TIME_BITS-1:0] time_ff, time_in;

   logic                 ov_ff, ov_in;
   logic [2:0]           ost_ff, ost_in;
   logic [15:0]          oconn_ff, oconn_in;
   logic [TIME_BITS-1:0] otime_ff, otime_in;
   logic [3:0]           ocnt_ff, ocnt_in;
   logic                 olast_ff, olast_in;

   logic [15:0]          conn_mem [DEPTH];
   logic [TIME_BITS-1:0] time_mem [DEPTH];
   logic [15:0]          rd_conn_ff;
   logic [TIME_BITS-1:0] rd_time_ff;
   logic                 mem_we, rd_en;
   logic [IW-1:0]        mem_waddr, rd_addr;
   logic [15:0]          mem_wconn;
   logic [TIME_BITS-1:0] mem_wtime;

   logic                 out_free;
   logic                 full;
   logic                 mod_start, mod_done;
   logic [OW-1:0]        mod_rem;
   logic [IW-1:0]        draw;
   logic [IW-1:0]        slot_p, slot_w, slot_occ, slot_one;
   logic [OW:0]          occ_plus;
   logic                 keep;
   logic                 walk_end;

   // queue position to memory slot, one compare and subtract
   function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                             input logic [OW-1:0] pos);
      logic [IW:0] s;
      s = {1'b0, head} + (IW+1)'(pos);
      if (s >= (IW+1)'(DEPTH)) begin
         s = s - (IW+1)'(DEPTH);
      end
      return IW'(s);
   endfunction

   assign slot_p   = slot_of(head_ff, p_ff);
   assign slot_w   = slot_of(head_ff, w_ff);
   assign slot_occ = slot_of(head_ff, occ_ff);
   assign slot_one = slot_of(head_ff, OW'(1));
   assign occ_plus = {1'b0, occ_ff} + (OW+1)'(1);
   assign full     = (LW'(occ_ff) >= LW'(queue_limit)) || (occ_ff == OW'(DEPTH));
   assign out_free = !ov_ff || rsp_ready;
   assign draw     = IW'(mod_rem);
   assign keep     = !mask_ff[p_ff[IW-1:0]];
   assign walk_end = ((p_ff + OW'(1)) == occ_ff);

   bqrhd_mod #(
      .OW (OW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (lfsr_step(lfsr_ff)),
      .divisor   (occ_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               priority case (q_cmd)
                  CMD_ENQ:  state_in = BK_ENQ;
                  CMD_DEQ:  state_in = (occ_ff == '0) ? BK_EMPTY : BK_DEQ_RD;
                  CMD_DROP: state_in = (occ_ff == '0) ? BK_EMPTY : BK_DRAW;
                  default:  state_in = BK_IDLE;
               endcase
            end
         end
         BK_ENQ, BK_EMPTY, BK_DEQ_EMIT: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         BK_DEQ_RD:  state_in = BK_DEQ_EMIT;
         BK_DRAW:    state_in = BK_MOD_WAIT;
         BK_MOD_WAIT: begin
            if (mod_done) begin
               if (mask_ff[draw] || ((cnt_ff + OW'(1)) != n_ff)) begin
                  state_in = BK_DRAW;
               end else begin
                  state_in = BK_WALK_RD;
               end
            end
         end
         BK_WALK_RD: state_in = BK_WALK_CHK;
         BK_WALK_CHK: begin
            if (keep || out_free) begin
               state_in = walk_end ? BK_IDLE : BK_WALK_RD;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath and outputs per state
   always_comb begin
      occ_in    = occ_ff;
      head_in   = head_ff;
      lfsr_in   = lfsr_ff;
      mask_in   = mask_ff;
      n_in      = n_ff;
      cnt_in    = cnt_ff;
      p_in      = p_ff;
      w_in      = w_ff;
      k_in      = k_ff;
      conn_in   = conn_ff;
      time_in   = time_ff;
      q_pop     = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = slot_w;
      mem_wconn = rd_conn_ff;
      mem_wtime = rd_time_ff;
      rd_en     = 1'b0;
      rd_addr   = slot_p;
      mod_start = 1'b0;
      ov_in     = ov_ff && !rsp_ready;
      ost_in    = ost_ff;
      oconn_in  = oconn_ff;
      otime_in  = otime_ff;
      ocnt_in   = ocnt_ff;
      olast_in  = olast_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               conn_in = q_conn;
               time_in = q_time;
               n_in    = OW'(occ_plus >> 1);
               cnt_in  = '0;
               mask_in = '0;
            end
         end
         BK_ENQ: begin
            if (out_free) begin
               ov_in    = 1'b1;
               oconn_in = '0;
               otime_in = '0;
               ocnt_in  = 4'd0;
               olast_in = 1'b1;
               if (full) begin
                  ost_in = ST_FULL;
               end else begin
                  ost_in    = ST_ACCEPTED;
                  mem_we    = 1'b1;
                  mem_waddr = slot_occ;
                  mem_wconn = conn_ff;
                  mem_wtime = time_ff;
                  occ_in    = occ_ff + OW'(1);
               end
            end
         end
         BK_EMPTY: begin
            if (out_free) begin
               ov_in    = 1'b1;
               ost_in   = ST_EMPTY;
               oconn_in = '0;
               otime_in = '0;
               ocnt_in  = 4'd0;
               olast_in = 1'b1;
            end
         end
         BK_DEQ_RD: begin
            rd_en   = 1'b1;
            rd_addr = head_ff;
         end
         BK_DEQ_EMIT: begin
            if (out_free) begin
               ov_in    = 1'b1;
               ost_in   = ST_DEQUEUED;
               oconn_in = rd_conn_ff;
               otime_in = rd_time_ff;
               ocnt_in  = 4'd0;
               olast_in = 1'b1;
               head_in  = slot_one;
               occ_in   = occ_ff - OW'(1);
            end
         end
         BK_DRAW: begin
            lfsr_in   = lfsr_step(lfsr_ff);
            mod_start = 1'b1;
         end
         BK_MOD_WAIT: begin
            if (mod_done && !mask_ff[draw]) begin
               mask_in[draw] = 1'b1;
               cnt_in = cnt_ff + OW'(1);
               p_in   = '0;
               w_in   = '0;
               k_in   = '0;
            end
         end
         BK_WALK_RD: begin
            rd_en   = 1'b1;
            rd_addr = slot_p;
         end
         BK_WALK_CHK: begin
            if (keep || out_free) begin
               if (keep) begin
                  mem_we = 1'b1;
                  w_in   = w_ff + OW'(1);
               end else begin
                  ov_in    = 1'b1;
                  ost_in   = ST_REMOVED;
                  oconn_in = rd_conn_ff;
                  otime_in = rd_time_ff;
                  if ((k_ff + OW'(1)) == n_ff) begin
                     ocnt_in  = 4'(n_ff);
                     olast_in = 1'b1;
                  end else begin
                     ocnt_in  = 4'd0;
                     olast_in = 1'b0;
                  end
                  k_in = k_ff + OW'(1);
               end
               p_in = p_ff + OW'(1);
               if (walk_end) begin
                  occ_in  = keep ? (w_ff + OW'(1)) : w_ff;
                  mask_in = '0;
               end
            end
         end
         default: begin
            mask_in = mask_ff;
         end
      endcase
      // seed write overrides the generator
      if (seed_wr.seed_load) begin
         lfsr_in = (seed_wr.seed == 16'd0) ? SEED_RESET : seed_wr.seed;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         occ_ff   <= '0;
         head_ff  <= '0;
         lfsr_ff  <= SEED_RESET;
         mask_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         head_ff  <= head_in;
         lfsr_ff  <= lfsr_in;
         mask_ff  <= mask_in;
         ov_ff    <= ov_in;
      end
   end

   // payload and counters
   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      cnt_ff   <= cnt_in;
      p_ff     <= p_in;
      w_ff     <= w_in;
      k_ff     <= k_in;
      conn_ff  <= conn_in;
      time_ff  <= time_in;
      ost_ff   <= ost_in;
      oconn_ff <= oconn_in;
      otime_ff <= otime_in;
      ocnt_ff  <= ocnt_in;
      olast_ff <= olast_in;
   end

   // entry memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         conn_mem[mem_waddr] <= mem_wconn;
         time_mem[mem_waddr] <= mem_wtime;
      end
      if (rd_en) begin
         rd_conn_ff <= conn_mem[rd_addr];
         rd_time_ff <= time_mem[rd_addr];
      end
   end

   assign rsp_valid         = ov_ff;
   assign rsp_status        = ost_ff;
   assign rsp_out_conn      = oconn_ff;
   assign rsp_out_time      = otime_ff;
   assign rsp_removed_count = ocnt_ff;
   assign rsp_last          = olast_ff;

   // occupancy stays within the memory
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OW'(DEPTH))
      else $error("occupancy above depth");

   // chosen mask is clear between drops
   a_mask_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_IDLE) |-> (mask_ff == '0))
      else $error("chosen mask not cleared");

   // no more removals than the drop asked for
   a_walk_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_WALK_CHK) |-> (k_ff <= n_ff))
      else $error("too many removals");

   // remainder only arrives while a draw is pending
   a_mod_done: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == BK_MOD_WAIT))
      else $error("unexpected remainder");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the bounded queue with random half drop
// Sends enqueue, dequeue, drop-half and unused commands through the request
// channel. A local queue model predicts every response, including the LFSR
// draws of a drop, and each response transfer is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import bqrhd_pkg::*;

   localparam int QDEPTH = 16;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [2:0] ADDR_LIMIT = 3'd0;
   localparam logic [2:0] ADDR_SEED  = 3'd4;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      logic [15:0] conn;
      logic [47:0] stamp;
   } entry_type;

   typedef struct {
      logic [2:0]  status;
      logic [15:0] conn;
      logic [47:0] stamp;
      logic [3:0]  count;
      logic        last;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_command = '0;
   logic [15:0] req_conn_id = '0;
   logic [47:0] req_arrival_time = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic [15:0] rsp_out_conn;
   logic [47:0] rsp_out_time;
   logic [3:0] rsp_removed_count;
   logic rsp_last;

   // model of the queue contents and registers
   entry_type     queued_entries[$];
   logic [4:0]    limit_reg = LIMIT_RESET;
   logic [15:0]   lfsr_reg = SEED_RESET;
   response_type  expected_responses[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;
   int error_count = 0;
   int item_count = 0;
   int response_count = 0;
   int drop_count = 0;

   bounded_queue_random_half_drop DUT (
      .clock(clock), .reset(reset),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_conn_id(req_conn_id), .req_arrival_time(req_arrival_time),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_out_conn(rsp_out_conn), .rsp_out_time(rsp_out_time),
      .rsp_removed_count(rsp_removed_count), .rsp_last(rsp_last)
   );

   always #1 clock = ~clock;

   function automatic void push_response(logic [2:0] st, logic [15:0] c,
                                         logic [47:0] t, logic [3:0] n, logic l);
      response_type r;
      r.status = st; r.conn = c; r.stamp = t; r.count = n; r.last = l;
      expected_responses.push_back(r);
   endfunction

   // predict the responses of one accepted command and update the model
   function automatic void predict_command(logic [1:0] cmd, logic [15:0] c,
                                           logic [47:0] t);
      int lim;
      int occ;
      int n;
      int d;
      int k;
      logic [QDEPTH-1:0] chosen;
      entry_type e;
      entry_type kept[$];
      occ = queued_entries.size();
      case (cmd)
         CMD_ENQ: begin
            lim = (limit_reg > QDEPTH) ? QDEPTH : limit_reg;
            if (occ >= lim) begin
               push_response(ST_FULL, '0, '0, '0, 1'b1);
            end else begin
               e.conn = c; e.stamp = t;
               queued_entries.push_back(e);
               push_response(ST_ACCEPTED, '0, '0, '0, 1'b1);
            end
         end
         CMD_DEQ: begin
            if (occ == 0) begin
               push_response(ST_EMPTY, '0, '0, '0, 1'b1);
            end else begin
               e = queued_entries.pop_front();
               push_response(ST_DEQUEUED, e.conn, e.stamp, '0, 1'b1);
            end
         end
         CMD_DROP: begin
            n = (occ + 1) / 2;
            if (n == 0) begin
               push_response(ST_EMPTY, '0, '0, '0, 1'b1);
            end else begin
               chosen = '0;
               for (int i = 0; i < n; i++) begin
                  do begin
                     lfsr_reg = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS)
                                            : (lfsr_reg >> 1);
                     d = int'(lfsr_reg) % occ;
                  end while (chosen[d]);
                  chosen[d] = 1'b1;
               end
               k = 0;
               for (int p = 0; p < occ; p++) begin
                  if (chosen[p]) begin
                     k++;
                     push_response(ST_REMOVED, queued_entries[p].conn,
                                   queued_entries[p].stamp,
                                   (k == n) ? 4'(n) : 4'd0, k == n);
                  end else begin
                     kept.push_back(queued_entries[p]);
                  end
               end
               queued_entries = kept;
               drop_count++;
            end
         end
         default: ;
      endcase
   endfunction

   // receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // compare each response transfer with the oldest prediction
   always @(posedge clock) begin
      response_type x;
      if (!reset && rsp_valid && rsp_ready) begin
         response_count++;
         if (expected_responses.size() == 0) begin
            $display("%0t: unexpected response status %0d conn %h", $time,
                     rsp_status, rsp_out_conn);
            error_count++;
         end else begin
            x = expected_responses.pop_front();
            if (rsp_status !== x.status) begin
               $display("%0t: status expected %0d actual %0d", $time, x.status,
                        rsp_status);
               error_count++;
            end
            if (rsp_out_conn !== x.conn) begin
               $display("%0t: out_conn expected %h actual %h", $time, x.conn,
                        rsp_out_conn);
               error_count++;
            end
            if (rsp_out_time !== x.stamp) begin
               $display("%0t: out_time expected %h actual %h", $time, x.stamp,
                        rsp_out_time);
               error_count++;
            end
            if (rsp_removed_count !== x.count) begin
               $display("%0t: removed_count expected %0d actual %0d", $time,
                        x.count, rsp_removed_count);
               error_count++;
            end
            if (rsp_last !== x.last) begin
               $display("%0t: last expected %0d actual %0d", $time, x.last,
                        rsp_last);
               error_count++;
            end
         end
      end
   end

   // one command transfer, with an optional random gap before it
   task automatic send_command(logic [1:0] cmd, logic [15:0] c, logic [47:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_conn_id <= c;
      req_arrival_time <= t;
      do @(posedge clock); while (!req_ready);
      predict_command(cmd, c, t);
      item_count++;
   endtask

   function automatic logic [47:0] random_stamp();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // wait until every predicted response has arrived, then let the block settle
   task automatic wait_drained();
      int n;
      n = 0;
      req_valid <= 1'b0;
      while (expected_responses.size() != 0 && n < 100000) begin
         @(posedge clock);
         n++;
      end
      if (expected_responses.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time,
                  expected_responses.size());
         error_count++;
         expected_responses.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [2:0] addr, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_LIMIT) begin
         limit_reg = value[4:0];
      end else begin
         lfsr_reg = (value[15:0] == 16'd0) ? 16'd1 : value[15:0];
      end
   endtask

   // extremes of the fields, each command, and the corner cases
   task automatic test_directed();
      send_command(CMD_DEQ, 16'hFFFF, '1);
      send_command(CMD_DROP, '0, '0);
      send_command(CMD_ENQ, 16'h0000, 48'h0);
      send_command(CMD_ENQ, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
      send_command(CMD_ENQ, 16'h5A5A, 48'h1234_5678_9ABC);
      send_command(CMD_DEQ, '0, '0);
      send_command(CMD_ENQ, 16'hA5A5, 48'hFEDC_BA98_7654);
      send_command(CMD_DROP, '0, '0);
      send_command(CMD_UNUSED, 16'h1111, 48'h1);
      wait_drained();
      // limit of zero drops every enqueue
      write_register(ADDR_LIMIT, 32'd0);
      send_command(CMD_ENQ, 16'h0001, 48'h2);
      wait_drained();
      // limit equal to occupancy keeps the entries
      write_register(ADDR_LIMIT, 32'd1);
      send_command(CMD_ENQ, 16'h0002, 48'h3);
      send_command(CMD_DEQ, '0, '0);
      send_command(CMD_ENQ, 16'h0003, 48'h4);
      send_command(CMD_ENQ, 16'h0004, 48'h5);
      wait_drained();
      // limit above depth saturates, zero seed loads one
      write_register(ADDR_LIMIT, 32'd31);
      write_register(ADDR_SEED, 32'd0);
      for (int i = 0; i < 5; i++) send_command(CMD_ENQ, 16'($urandom), random_stamp());
      send_command(CMD_DROP, '0, '0);
      wait_drained();
      write_register(ADDR_SEED, 32'd65535);
      send_command(CMD_DROP, '0, '0);
      send_command(CMD_DROP, '0, '0);
      wait_drained();
   endtask

   // receiver holds off while the sender overfills the queue
   task automatic test_backpressure();
      write_register(ADDR_LIMIT, 32'd16);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_left = 300;
      for (int i = 0; i < 18; i++) send_command(CMD_ENQ, 16'($urandom), random_stamp());
      send_command(CMD_DROP, '0, '0);
      send_command(CMD_DROP, '0, '0);
      send_command(CMD_DEQ, '0, '0);
      wait_drained();
   endtask

   // random commands, mostly enqueues so that drops see a full queue
   task automatic test_random_phase(int count, int send_pct, int recv_pct);
      int r;
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      case ($urandom_range(3))
         0: write_register(ADDR_LIMIT, 32'd16);
         1: write_register(ADDR_LIMIT, 32'd1);
         2: write_register(ADDR_LIMIT, 32'd31);
         default: write_register(ADDR_LIMIT, 32'($urandom_range(31)));
      endcase
      write_register(ADDR_SEED, (($urandom_range(3) == 0) ? 32'd0 : 32'($urandom)));
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 58) send_command(CMD_ENQ, 16'($urandom), random_stamp());
         else if (r < 78) send_command(CMD_DEQ, 16'($urandom), random_stamp());
         else if (r < 96) send_command(CMD_DROP, 16'($urandom), random_stamp());
         else send_command(CMD_UNUSED, 16'($urandom), random_stamp());
      end
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random_phase(50, 0, 0);
      test_random_phase(50, 46, 0);
      test_random_phase(50, 0, 46);
      test_random_phase(50, 32, 32);
      repeat (100) @(posedge clock);
      $display("covered %0d commands, %0d responses, %0d random drops", item_count,
               response_count, drop_count);
      $display("phases: directed corners, held-off receiver, four idle mixes");
      if (error_count == 0 && expected_responses.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #1500000;
      $display("simulation failed");
      $finish;
   end

endmodule
`default_nettype wire
